@@ sv/nsrg_pkg.sv @@
// Package for the natural-selection run generator.
// Holds field widths, default parameter values, sequencer codes and the key
// normalization used by the shared comparator. No dependencies.
package nsrg_pkg;

	// Field widths of the item ports
	localparam int KEY_W      = 64;
	localparam int TAG_PORT_W = 32;
	localparam int RUN_W      = 16;
	localparam int CFG_W      = 5;
	localparam int S_DATA_W   = KEY_W + TAG_PORT_W;
	localparam int M_DATA_W   = KEY_W + TAG_PORT_W + RUN_W;

	// Defaults for the top-level parameters
	localparam int SLOTS_DEF     = 16;
	localparam int KEY_CHARS_DEF = 8;
	localparam int TAG_BITS_DEF  = 32;

	// Reset value of the slot-count register
	localparam logic [CFG_W-1:0] MEM_SLOTS_RST = CFG_W'(16);

	// Input command codes
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_EMIT   = 5'b01000,
		ST_COPY   = 5'b10000
	} state_t;

	// What the scan/emit loop is doing
	typedef enum logic [1:0] {
		MD_ONE,          // emit the least key once, then take the next item
		MD_RUN_END,      // reservoir full: drain memory, refill from reservoir
		MD_FLUSH_MEM,    // end of input: drain memory
		MD_FLUSH_SPARE   // end of input: drain the former reservoir
	} mode_t;

	// Fold letters to upper case and zero every byte after the first zero
	// byte or past the compared length, so a plain unsigned compare gives
	// the key order.
	function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k,
			input int unsigned chars);
		logic [KEY_W-1:0] r;
		logic [7:0]       c;
		logic             dead;
		r    = '0;
		dead = 1'b0;
		for (int i = 0; i < 8; i++) begin
			c = k[KEY_W-1-8*i -: 8];
			if (c inside {[8'h61:8'h7A]}) begin
				c = c - 8'h20;
			end
			if (i >= chars) begin
				dead = 1'b1;
			end
			if (!dead) begin
				r[KEY_W-1-8*i -: 8] = c;
			end
			if (c == 8'h00) begin
				dead = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

@@ sv/natural_selection_run_generator_top.sv @@
// A record that fills a slot or enters the reservoir passes IDLE and DECIDE only.
// A record that causes an emission passes accept, decide, one pass of the shared
// key comparator over the m slots in use (scan), then emit.
// A drain repeats scan and emit per record, then copies any reservoir records in.
// One item at a time; a held output item stalls the emit step.
// Reset clears control state and sets the slot count to 16; storage is undefined.
module natural_selection_run_generator_top #(
	parameter int SLOTS     = nsrg_pkg::SLOTS_DEF,
	parameter int KEY_CHARS = nsrg_pkg::KEY_CHARS_DEF,
	parameter int TAG_BITS  = nsrg_pkg::TAG_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [nsrg_pkg::S_DATA_W-1:0] s_tdata,   // key[63:0], tag[95:64]
	input  logic                          s_tuser,   // cmd
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [nsrg_pkg::M_DATA_W-1:0] m_tdata,   // out_key[63:0], out_tag[95:64],
	                                                 // run_index[111:96]
	output logic                          m_tlast,   // last_in_run
	// slot-count register
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nsrg_pkg::CFG_W-1:0]    cfg_data   // mem_slots
);
	import nsrg_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int TW    = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;

	// Slot and reservoir storage
	logic [KEY_W-1:0] slot_key_q  [SLOTS];
	logic [TW-1:0]    slot_tag_q  [SLOTS];
	logic [KEY_W-1:0] spare_key_q [SLOTS];
	logic [TW-1:0]    spare_tag_q [SLOTS];
	logic [SLOTS-1:0] slot_valid_q;

	// Control state
	state_t           state_q;
	mode_t            mode_q;
	logic [CFG_W-1:0] mem_slots_q;
	logic             filling_q;
	logic [CNT_W-1:0] fill_count_q;
	logic [CNT_W-1:0] spare_count_q;
	logic [CNT_W-1:0] live_q;
	logic [RUN_W-1:0] run_counter_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] copy_idx_q;
	logic [IDX_W-1:0] emitted_q;
	logic             found_q;
	logic             m_tvalid_q;

	// Payload registers
	logic             in_cmd_q;
	logic [KEY_W-1:0] in_key_q;
	logic [TW-1:0]    in_tag_q;
	logic [KEY_W-1:0] best_norm_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [KEY_W-1:0] last_norm_q;
	logic [KEY_W-1:0] out_key_q;
	logic [TW-1:0]    out_tag_q;
	logic [RUN_W-1:0] out_run_q;
	logic             out_last_q;

	// Datapath signals
	logic [CW-1:0]    raw_slots;
	logic [CW-1:0]    clamp_slots;
	logic [CNT_W-1:0] eff_m;
	logic [IDX_W-1:0] rd_addr;
	logic [KEY_W-1:0] rd_key;
	logic [TW-1:0]    rd_tag;
	logic [KEY_W-1:0] cmp_raw;
	logic [KEY_W-1:0] cmp_norm;
	logic [KEY_W-1:0] cmp_ref;
	logic             less;
	logic             hit;
	logic             found_n;
	logic             scan_end;
	logic             copy_end;
	logic             out_free;
	logic             last_flag;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [KEY_W-1:0] wr_key;
	logic [TW-1:0]    wr_tag;
	logic             sp_wr_en;
	logic             fill_done;
	logic             spare_full;

	// Clamp the slot count to 1..SLOTS
	always_comb begin
		raw_slots = CW'(mem_slots_q);
		if (raw_slots == '0) begin
			clamp_slots = CW'(1);
		end else if (raw_slots > CW'(SLOTS)) begin
			clamp_slots = CW'(SLOTS);
		end else begin
			clamp_slots = raw_slots;
		end
		eff_m = CNT_W'(clamp_slots);
	end

	// Single read port of the slot store
	assign rd_addr = (state_q == ST_EMIT) ? best_idx_q : scan_idx_q;
	assign rd_key  = slot_key_q[rd_addr];
	assign rd_tag  = slot_tag_q[rd_addr];

	// Shared key comparator: incoming record against the last emitted key,
	// or a scanned slot against the best key found so far
	assign cmp_raw  = (state_q == ST_DECIDE) ? in_key_q : rd_key;
	assign cmp_ref  = (state_q == ST_DECIDE) ? last_norm_q : best_norm_q;
	assign cmp_norm = norm_key(cmp_raw, KEY_CHARS);
	assign less     = cmp_norm < cmp_ref;

	// Scan bookkeeping
	assign hit      = slot_valid_q[scan_idx_q] && (!found_q || less);
	assign found_n  = found_q || hit;
	assign scan_end = CNT_W'(scan_idx_q) == (eff_m - 1'b1);
	assign copy_end = (CNT_W'(copy_idx_q) + 1'b1) == spare_count_q;

	assign fill_done  = (fill_count_q + 1'b1) >= eff_m;
	assign spare_full = (spare_count_q + 1'b1) >= eff_m;

	assign out_free  = !m_tvalid_q || m_tready;
	assign last_flag = (mode_q != MD_ONE) && (live_q == CNT_W'(1));

	// Slot write port: fill, replacement of the emitted slot, reservoir copy
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = emitted_q;
		wr_key   = in_key_q;
		wr_tag   = in_tag_q;
		sp_wr_en = 1'b0;
		case (state_q)
			ST_DECIDE: begin
				if (in_cmd_q == CMD_RECORD) begin
					if (filling_q) begin
						wr_en   = 1'b1;
						wr_addr = fill_count_q[IDX_W-1:0];
					end else if (less) begin
						sp_wr_en = 1'b1;
					end else begin
						wr_en = 1'b1;
					end
				end
			end
			ST_COPY: begin
				wr_en   = 1'b1;
				wr_addr = copy_idx_q;
				wr_key  = spare_key_q[copy_idx_q];
				wr_tag  = spare_tag_q[copy_idx_q];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Storage arrays
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_key_q[wr_addr] <= wr_key;
			slot_tag_q[wr_addr] <= wr_tag;
		end
		if (sp_wr_en) begin
			spare_key_q[spare_count_q[IDX_W-1:0]] <= in_key_q;
			spare_tag_q[spare_count_q[IDX_W-1:0]] <= in_tag_q;
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= MD_ONE;
			mem_slots_q   <= MEM_SLOTS_RST;
			filling_q     <= 1'b1;
			fill_count_q  <= '0;
			spare_count_q <= '0;
			live_q        <= '0;
			run_counter_q <= '0;
			scan_idx_q    <= '0;
			copy_idx_q    <= '0;
			emitted_q     <= '0;
			found_q       <= 1'b0;
			slot_valid_q  <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			// accept a slot-count write only between streams
			if (cfg_valid && filling_q && fill_count_q == '0 && spare_count_q == '0) begin
				mem_slots_q <= cfg_data;
			end

			// load a new output item, or drop the held one once taken
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// mark written slots
			if (wr_en) begin
				slot_valid_q[wr_addr] <= 1'b1;
				live_q                <= live_q + 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DECIDE;
					end
				end

				ST_DECIDE: begin
					scan_idx_q <= '0;
					found_q    <= 1'b0;
					if (in_cmd_q == CMD_FLUSH) begin
						mode_q  <= MD_FLUSH_MEM;
						state_q <= ST_SCAN;
					end else if (filling_q) begin
						fill_count_q <= fill_count_q + 1'b1;
						if (fill_done) begin
							filling_q <= 1'b0;
							mode_q    <= MD_ONE;
							state_q   <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (less) begin
						spare_count_q <= spare_count_q + 1'b1;
						if (spare_full) begin
							mode_q  <= MD_RUN_END;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						mode_q  <= MD_ONE;
						state_q <= ST_SCAN;
					end
				end

				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + 1'b1;
					found_q    <= found_n;
					if (scan_end) begin
						if (found_n) begin
							state_q <= ST_EMIT;
						end else begin
							// memory empty: close this phase
							copy_idx_q <= '0;
							case (mode_q)
								MD_RUN_END: begin
									run_counter_q <= run_counter_q + 1'b1;
									mode_q        <= MD_ONE;
									state_q       <= ST_COPY;
								end
								MD_FLUSH_MEM: begin
									if (spare_count_q != '0) begin
										run_counter_q <= run_counter_q + 1'b1;
										mode_q        <= MD_FLUSH_SPARE;
										state_q       <= ST_COPY;
									end else begin
										filling_q     <= 1'b1;
										fill_count_q  <= '0;
										spare_count_q <= '0;
										live_q        <= '0;
										run_counter_q <= '0;
										emitted_q     <= '0;
										slot_valid_q  <= '0;
										mode_q        <= MD_ONE;
										state_q       <= ST_IDLE;
									end
								end
								MD_FLUSH_SPARE: begin
									filling_q     <= 1'b1;
									fill_count_q  <= '0;
									spare_count_q <= '0;
									live_q        <= '0;
									run_counter_q <= '0;
									emitted_q     <= '0;
									slot_valid_q  <= '0;
									mode_q        <= MD_ONE;
									state_q       <= ST_IDLE;
								end
								default: begin
									state_q <= ST_IDLE;
								end
							endcase
						end
					end
				end

				ST_EMIT: begin
					if (out_free) begin
						slot_valid_q[best_idx_q] <= 1'b0;
						live_q                   <= live_q - 1'b1;
						emitted_q                <= best_idx_q;
						scan_idx_q               <= '0;
						found_q                  <= 1'b0;
						if (mode_q == MD_ONE) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end

				ST_COPY: begin
					copy_idx_q <= copy_idx_q + 1'b1;
					if (copy_end) begin
						spare_count_q <= '0;
						scan_idx_q    <= '0;
						found_q       <= 1'b0;
						state_q       <= ST_SCAN;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: input capture, running minimum, output item
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_cmd_q <= s_tuser;
			in_key_q <= s_tdata[KEY_W-1:0];
			in_tag_q <= s_tdata[KEY_W +: TW];
		end
		if (state_q == ST_SCAN && hit) begin
			best_norm_q <= cmp_norm;
			best_idx_q  <= scan_idx_q;
		end
		if (state_q == ST_EMIT && out_free) begin
			last_norm_q <= best_norm_q;
			out_key_q   <= rd_key;
			out_tag_q   <= rd_tag;
			out_run_q   <= run_counter_q;
			out_last_q  <= last_flag;
		end
	end

	// Ports
	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {out_run_q, TAG_PORT_W'(out_tag_q), out_key_q};
	assign m_tlast   = out_last_q;

endmodule

@@ test/nsrg_run_checker.sv @@
// Checker for the natural-selection run generator: watches the input, result and
// slot-count channels, predicts every emitted record and compares it field by field.
// Depends on nsrg_pkg for field widths, the slot default and the command codes.
module nsrg_run_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [nsrg_pkg::S_DATA_W-1:0] s_tdata,    // key[63:0], tag[95:64]
	input  logic                          s_tuser,    // cmd
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [nsrg_pkg::M_DATA_W-1:0] m_tdata,    // out_key[63:0], out_tag[95:64],
	                                                  // run_index[111:96]
	input  logic                          m_tlast,    // last_in_run
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [nsrg_pkg::CFG_W-1:0]    cfg_data,   // mem_slots
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import nsrg_pkg::*;

	localparam int SLOTS = SLOTS_DEF;

	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [TAG_PORT_W-1:0] tag;
		logic [RUN_W-1:0]      run;
		logic                  last;
	} emitted_t;

	// Expected records, oldest first
	emitted_t expect_q[$];

	// Predicted block state
	logic [KEY_W-1:0]      mem_key[SLOTS];
	logic [TAG_PORT_W-1:0] mem_tag[SLOTS];
	bit                    mem_live[SLOTS];
	logic [KEY_W-1:0]      res_key[SLOTS];
	logic [TAG_PORT_W-1:0] res_tag[SLOTS];
	int                    res_cnt;
	int                    last_slot;
	bit                    loading;
	int                    load_cnt;
	logic [RUN_W-1:0]      run_no;
	logic [CFG_W-1:0]      slots_reg;
	int                    errors;

	// Fold letters to upper case and blank everything after the first zero byte
	function automatic logic [KEY_W-1:0] sort_rank(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] r;
		logic [7:0]       ch;
		bit               ended;
		r = '0;
		ended = 1'b0;
		for (int i = 0; i < 8; i++) begin
			ch = k[KEY_W-1-8*i -: 8];
			// 'a'..'z'
			if (ch >= 8'h61 && ch <= 8'h7A) begin
				ch = ch - 8'h20;
			end
			if (ended) begin
				ch = 8'h00;
			end
			r[KEY_W-1-8*i -: 8] = ch;
			if (ch == 8'h00) begin
				ended = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic bit key_below(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		return sort_rank(a) < sort_rank(b);
	endfunction

	// Least live slot; ties go to the lowest index
	function int least_slot();
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (mem_live[i] && (best < 0 || key_below(mem_key[i], mem_key[best]))) begin
				best = i;
			end
		end
		return best;
	endfunction

	function void push_record(input int idx);
		emitted_t e;
		e.key = mem_key[idx];
		e.tag = mem_tag[idx];
		e.run = run_no;
		e.last = 1'b0;
		expect_q.push_back(e);
		mem_live[idx] = 1'b0;
	endfunction

	function void emit_least();
		int idx;
		idx = least_slot();
		if (idx >= 0) begin
			push_record(idx);
			last_slot = idx;
		end
	endfunction

	// Emit all of memory in key order; the final record closes the run
	function void drain_memory();
		int start;
		int idx;
		start = expect_q.size();
		idx = least_slot();
		while (idx >= 0) begin
			push_record(idx);
			idx = least_slot();
		end
		if (expect_q.size() > start) begin
			expect_q[expect_q.size()-1].last = 1'b1;
		end
	endfunction

	function void reservoir_to_memory();
		for (int i = 0; i < res_cnt; i++) begin
			mem_key[i] = res_key[i];
			mem_tag[i] = res_tag[i];
			mem_live[i] = 1'b1;
		end
		res_cnt = 0;
	endfunction

	// Back to an empty stream; the slot count is kept
	function void clear_stream();
		for (int i = 0; i < SLOTS; i++) begin
			mem_live[i] = 1'b0;
		end
		res_cnt = 0;
		last_slot = 0;
		loading = 1'b1;
		load_cnt = 0;
		run_no = '0;
	endfunction

	function void take_config(input logic [CFG_W-1:0] v);
		if (loading && load_cnt == 0 && res_cnt == 0) begin
			slots_reg = v;
		end
	endfunction

	function void step_model(input logic cmd, input logic [KEY_W-1:0] k,
			input logic [TAG_PORT_W-1:0] t);
		int m;
		int held;
		m = (slots_reg == 0) ? 1 : ((int'(slots_reg) > SLOTS) ? SLOTS : int'(slots_reg));
		// End of input: memory as the current run, then the reservoir as one more
		if (cmd == CMD_FLUSH) begin
			held = expect_q.size();
			drain_memory();
			if (!loading || expect_q.size() > held) begin
				run_no = run_no + 1'b1;
			end
			if (res_cnt > 0) begin
				reservoir_to_memory();
				drain_memory();
			end
			clear_stream();
			return;
		end
		// Fill memory, emit the least key once it is full
		if (loading) begin
			if (load_cnt < SLOTS) begin
				mem_key[load_cnt] = k;
				mem_tag[load_cnt] = t;
				mem_live[load_cnt] = 1'b1;
				load_cnt++;
			end
			if (load_cnt >= m) begin
				loading = 1'b0;
				emit_least();
			end
		end else if (key_below(k, mem_key[last_slot])) begin
			// Below the last emitted key: park it, end the run when the reservoir fills
			if (res_cnt < SLOTS) begin
				res_key[res_cnt] = k;
				res_tag[res_cnt] = t;
				res_cnt++;
			end
			if (res_cnt >= m) begin
				drain_memory();
				run_no = run_no + 1'b1;
				reservoir_to_memory();
				emit_least();
			end
		end else begin
			// Take the freed slot and emit the next least key
			mem_key[last_slot] = k;
			mem_tag[last_slot] = t;
			mem_live[last_slot] = 1'b1;
			emit_least();
		end
	endfunction

	function void report_field(input string field, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want, got);
			errors++;
		end
	endfunction

	function void check_record();
		emitted_t e;
		if (expect_q.size() == 0) begin
			$display("%0t ns: record with none expected, key %h tag %h run %h last %b",
				$time, m_tdata[63:0], m_tdata[95:64], m_tdata[111:96], m_tlast);
			errors++;
			return;
		end
		e = expect_q.pop_front();
		report_field("out_key", e.key, m_tdata[63:0]);
		report_field("out_tag", 64'(e.tag), 64'(m_tdata[95:64]));
		report_field("run_index", 64'(e.run), 64'(m_tdata[111:96]));
		report_field("last_in_run", 64'(e.last), 64'(m_tlast));
	endfunction

	// Follow every handshake; publish the counts as registered outputs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q.delete();
			clear_stream();
			slots_reg = MEM_SLOTS_RST;
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				take_config(cfg_data);
			end
			if (s_tvalid && s_tready) begin
				step_model(s_tuser, s_tdata[63:0], s_tdata[95:64]);
			end
			if (m_tvalid && m_tready) begin
				check_record();
			end
			pending <= expect_q.size();
			fail_count <= errors;
		end
	end

endmodule

@@ test/tb_natural_selection_run_generator_top.sv @@
// Testbench top for the natural-selection run generator: clock, reset, directed and
// random record streams, slot-count changes, back-pressure and the verdict.
// Depends on nsrg_pkg, natural_selection_run_generator_top and nsrg_run_checker.
module tb_natural_selection_run_generator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nsrg_pkg::*;

	localparam int LIMIT_CYCLES  = 1000000;
	localparam int TAIL_CYCLES   = 64;
	localparam int PLANNED_ITEMS = 320;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;

	int               fail_count;
	int               pending;
	int               send_idle_pct = 8;
	int               recv_idle_pct = 65;
	int               items_sent;
	int               cycles;
	logic [KEY_W-1:0] prev_key;

	natural_selection_run_generator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	nsrg_run_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= (arst_n === 1'b1) && ($urandom_range(99) >= recv_idle_pct);
	end

	// Hard stop if the run hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("natural_selection_run_generator_top regression: fail");
			$finish;
		end
	end

	// Left-aligned text key, zero padded
	function automatic logic [KEY_W-1:0] text_key(input string s);
		logic [KEY_W-1:0] k;
		k = '0;
		for (int i = 0; i < s.len() && i < 8; i++) begin
			k[KEY_W-1-8*i -: 8] = s[i];
		end
		return k;
	endfunction

	// Mostly mixed-case words, some raw bit patterns, some case-flipped repeats
	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		logic [7:0]       ch;
		int               len;
		int               pos;
		case ($urandom_range(9))
			7: begin
				k = {$urandom, $urandom};
			end
			8: begin
				k = {$urandom, $urandom};
				pos = $urandom_range(7);
				k[8*pos +: 8] = 8'h00;
			end
			9: begin
				k = prev_key;
				for (int i = 0; i < 8; i++) begin
					ch = k[8*i +: 8];
					if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) begin
						if ($urandom_range(1) == 1) begin
							k[8*i +: 8] = ch ^ 8'h20;
						end
					end
				end
			end
			default: begin
				k = '0;
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					ch = 8'h41 + 8'($urandom_range(25));
					if ($urandom_range(1) == 1) begin
						ch = ch | 8'h20;
					end
					k[KEY_W-1-8*i -: 8] = ch;
				end
			end
		endcase
		prev_key = k;
		return k;
	endfunction

	// Present one item, hold it until accepted, then advance the idle profile
	task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
			input logic [TAG_PORT_W-1:0] tag);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {tag, key};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		items_sent++;
		if (items_sent >= 2 * PLANNED_ITEMS / 3) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end else if (items_sent >= PLANNED_ITEMS / 3) begin
			send_idle_pct = 65;
			recv_idle_pct = 8;
		end
	endtask

	task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_PORT_W-1:0] tag);
		send_item(CMD_RECORD, key, tag);
	endtask

	task automatic end_stream();
		send_item(CMD_FLUSH, {$urandom, $urandom}, $urandom);
	endtask

	// Drop valid, wait for every expected record, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_slots(input int slots);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= CFG_W'(slots);
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int phase;
		int slots;
		int len;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_RECORD;
		cfg_valid <= 1'b0;
		cfg_data <= MEM_SLOTS_RST;
		prev_key = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// End of input with nothing stored
		end_stream();

		// Short stream at the reset slot count: extreme keys, case folding, ties, prefixes
		send_record('1, '0);
		send_record('0, '1);
		send_record(text_key("abc"), 32'd1);
		send_record(text_key("ABC"), 32'd2);
		send_record(text_key("AB"), 32'd3);
		end_stream();

		// Two slots: reservoir fills and ends a run, then end of input
		write_slots(2);
		send_record(text_key("M"), 32'd10);
		send_record(text_key("D"), 32'd11);
		send_record(text_key("A"), 32'd12);
		send_record(text_key("Z"), 32'd13);
		send_record(text_key("b"), 32'd14);
		end_stream();

		// Single slot: runs close without a last marker
		write_slots(1);
		send_record(text_key("C"), 32'd20);
		send_record(text_key("A"), 32'd21);
		send_record(text_key("B"), 32'd22);
		send_record(text_key("d"), 32'd23);
		end_stream();

		// Random streams over several slot counts, some shorter than memory
		phase = 0;
		while (items_sent < PLANNED_ITEMS) begin
			case (phase % 5)
				0: slots = 16;
				1: slots = 1;
				3: slots = 4;
				default: slots = $urandom_range(1, 16);
			endcase
			write_slots(slots);
			if ($urandom_range(5) == 0) begin
				len = $urandom_range(0, slots - 1);
			end else begin
				len = $urandom_range(slots, 3 * slots + 6);
			end
			repeat (len) send_record(rand_key(), $urandom);
			end_stream();
			phase++;
		end

		settle();
		if (fail_count == 0) begin
			$display("natural_selection_run_generator_top regression: pass");
		end else begin
			$display("natural_selection_run_generator_top regression: fail");
		end
		$finish;
	end

endmodule
